// ===== design/pffla_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator package
// Sizes, item kinds, status codes and sequencer states shared by the design.
// ----------------------------------------------------------------------------
package pffla_pkg;

   localparam int MAX_REGIONS  = 16;
   localparam int MAX_RESERVED = 256;
   localparam int POOL_DEPTH   = 1024;
   localparam int FRAME_BITS   = 36;
   localparam int COUNT_BITS   = 36;
   localparam int ADD_LIMIT    = 64;

   localparam int REG_IDX_W = $clog2(MAX_REGIONS);
   localparam int REG_CNT_W = REG_IDX_W + 1;
   localparam int RES_IDX_W = $clog2(MAX_RESERVED);
   localparam int RES_CNT_W = RES_IDX_W + 1;
   localparam int POOL_IDX_W = $clog2(POOL_DEPTH);
   localparam int POOL_CNT_W = POOL_IDX_W + 1;
   localparam int TARGET_W   = 7;

   localparam logic [FRAME_BITS-1:0] NULL_FRAME = '0;

   typedef enum logic [2:0] {
      KIND_ADD_REGION   = 3'd0,
      KIND_ADD_RESERVED = 3'd1,
      KIND_REFILL       = 3'd2,
      KIND_ALLOC        = 3'd3,
      KIND_FREE         = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CARVE_RD,
      ST_CARVE,
      ST_POP_RD,
      ST_POP,
      ST_DONE
   } state_type;

endpackage

// ===== design/page_frame_free_list_allocator.sv =====
// Add region, add reserved, free, unused kinds and a refill with no region left
// go from idle straight to the response register. Alloc reads and pops the
// pool; on an empty pool with a region left it first carves or skips frames up
// to the target. A refill with a region left carves or skips frames up to the
// target, then responds. One transaction in flight;
// a stalled response holds the input. Sync active-high reset, target 64.
// ----------------------------------------------------------------------------
// Page frame free-list allocator
// LIFO frame pool refilled by carving frames from loaded regions, skipping
// reserved frames, under a small sequencer with one carve step unit.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator
   import pffla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [35:0] frame_number, [71:36] frame_count
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [35:0] out_frame, [46:36] pool_count, pad
   output logic [2:0]  rsp_tuser,   // [0] frame_valid, [2:1] status
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [TARGET_W-1:0]   target_ff;
   logic [FRAME_BITS-1:0] region_base_ff [MAX_REGIONS];
   logic [COUNT_BITS-1:0] region_left_ff [MAX_REGIONS];
   logic [REG_CNT_W-1:0]  loaded_ff, remaining_ff, cur_ff;
   logic [FRAME_BITS-1:0] reserved_mem [MAX_RESERVED];
   logic [FRAME_BITS-1:0] res_rd_ff;
   logic [RES_CNT_W-1:0]  front_ff, end_ff;
   logic [FRAME_BITS-1:0] stack_mem [POOL_DEPTH];
   logic [FRAME_BITS-1:0] stack_rd_ff;
   logic [POOL_CNT_W-1:0] count_ff;

   logic [2:0]            kind_ff;
   logic [FRAME_BITS-1:0] res_frame_ff;
   logic                  res_valid_ff;
   status_type            res_status_ff;

   logic                  rsp_valid_ff;
   logic [47:0]           rsp_data_ff;
   logic [2:0]            rsp_user_ff;

   logic                  accept;
   logic [2:0]            req_kind;
   logic [FRAME_BITS-1:0] req_frame;
   logic [COUNT_BITS-1:0] req_count;
   logic [TARGET_W-1:0]   target_eff;
   logic                  regions_open;
   logic                  carve_go;
   logic [REG_IDX_W-1:0]  cur_idx;
   logic [FRAME_BITS-1:0] cur_base;
   logic [FRAME_BITS-1:0] res_entry;
   logic                  res_hit;
   logic [POOL_CNT_W-1:0] pop_cnt;
   logic                  rsp_load;

   assign accept    = req_tvalid && req_tready;
   assign req_kind  = req_tuser;
   assign req_frame = req_tdata[FRAME_BITS-1:0];
   assign req_count = req_tdata[FRAME_BITS +: COUNT_BITS];

   // clamp target into 1..ADD_LIMIT
   always_comb begin
      target_eff = target_ff;
      if (target_ff == '0) begin
         target_eff = TARGET_W'(1);
      end else if (target_ff > TARGET_W'(ADD_LIMIT)) begin
         target_eff = TARGET_W'(ADD_LIMIT);
      end
   end

   assign regions_open = (remaining_ff != '0) && (cur_ff < REG_CNT_W'(MAX_REGIONS));
   assign carve_go     = regions_open && (count_ff < POOL_CNT_W'(target_eff));
   assign cur_idx      = cur_ff[REG_IDX_W-1:0];
   assign cur_base     = region_base_ff[cur_idx];
   // entry zero is the null frame and is never written
   assign res_entry    = (front_ff == '0) ? NULL_FRAME : res_rd_ff;
   assign res_hit      = (front_ff < end_ff) && (front_ff < RES_CNT_W'(MAX_RESERVED))
                         && (res_entry == cur_base);
   assign pop_cnt      = count_ff - POOL_CNT_W'(1);
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == KIND_REFILL) begin
                  state_in = regions_open ? ST_CARVE_RD : ST_DONE;
               end else if (req_kind == KIND_ALLOC) begin
                  state_in = (count_ff == '0 && regions_open) ? ST_CARVE_RD : ST_POP_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CARVE_RD: begin
            if (carve_go) begin
               state_in = ST_CARVE;
            end else if (kind_ff == KIND_ALLOC) begin
               state_in = ST_POP_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CARVE: state_in = ST_CARVE_RD;
         ST_POP_RD: state_in = (count_ff != '0) ? ST_POP : ST_DONE;
         ST_POP: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // memories: reserved list and frame stack
   always_ff @(posedge clock) begin
      res_rd_ff   <= reserved_mem[front_ff[RES_IDX_W-1:0]];
      stack_rd_ff <= stack_mem[pop_cnt[POOL_IDX_W-1:0]];
      if (accept && req_kind == KIND_ADD_RESERVED && end_ff < RES_CNT_W'(MAX_RESERVED)) begin
         reserved_mem[end_ff[RES_IDX_W-1:0]] <= req_frame;
      end
      if (accept && req_kind == KIND_FREE && count_ff < POOL_CNT_W'(POOL_DEPTH)) begin
         stack_mem[count_ff[POOL_IDX_W-1:0]] <= req_frame;
      end else if (state_ff == ST_CARVE && !res_hit
                   && count_ff < POOL_CNT_W'(POOL_DEPTH)) begin
         stack_mem[count_ff[POOL_IDX_W-1:0]] <= cur_base;
      end
   end

   // region table
   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_ADD_REGION && req_count != '0
          && loaded_ff < REG_CNT_W'(MAX_REGIONS)) begin
         region_base_ff[loaded_ff[REG_IDX_W-1:0]] <= req_frame;
         region_left_ff[loaded_ff[REG_IDX_W-1:0]] <= req_count;
      end else if (state_ff == ST_CARVE) begin
         region_base_ff[cur_idx] <= cur_base + FRAME_BITS'(1);
         region_left_ff[cur_idx] <= region_left_ff[cur_idx] - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req_kind;
         res_frame_ff <= NULL_FRAME;
         res_valid_ff <= 1'b0;
         res_status_ff <= STATUS_OK;
         case (req_kind)
            KIND_ADD_REGION: begin
               if (req_count != '0 && loaded_ff >= REG_CNT_W'(MAX_REGIONS)) begin
                  res_status_ff <= STATUS_FULL;
               end
            end
            KIND_ADD_RESERVED: begin
               if (end_ff >= RES_CNT_W'(MAX_RESERVED)) begin
                  res_status_ff <= STATUS_FULL;
               end
            end
            KIND_REFILL: begin
               if (!regions_open) begin
                  res_status_ff <= STATUS_EMPTY;
               end
            end
            KIND_FREE: begin
               if (count_ff >= POOL_CNT_W'(POOL_DEPTH)) begin
                  res_status_ff <= STATUS_FULL;
               end
            end
            default: ;
         endcase
      end else if (state_ff == ST_POP_RD && count_ff == '0) begin
         res_status_ff <= STATUS_EMPTY;
      end else if (state_ff == ST_POP) begin
         res_frame_ff <= stack_rd_ff;
         res_valid_ff <= 1'b1;
      end
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         remaining_ff <= '0;
         cur_ff       <= '0;
         front_ff     <= '0;
         end_ff       <= RES_CNT_W'(1);
         count_ff     <= '0;
      end else begin
         if (accept && req_kind == KIND_ADD_REGION && req_count != '0
             && loaded_ff < REG_CNT_W'(MAX_REGIONS)) begin
            loaded_ff    <= loaded_ff + REG_CNT_W'(1);
            remaining_ff <= remaining_ff + REG_CNT_W'(1);
         end
         if (accept && req_kind == KIND_ADD_RESERVED && end_ff < RES_CNT_W'(MAX_RESERVED)) begin
            end_ff <= end_ff + RES_CNT_W'(1);
         end
         if (accept && req_kind == KIND_FREE && count_ff < POOL_CNT_W'(POOL_DEPTH)) begin
            count_ff <= count_ff + POOL_CNT_W'(1);
         end
         if (state_ff == ST_CARVE) begin
            if (res_hit) begin
               front_ff <= front_ff + RES_CNT_W'(1);
            end else if (count_ff < POOL_CNT_W'(POOL_DEPTH)) begin
               count_ff <= count_ff + POOL_CNT_W'(1);
            end
            // advance to the next region once this one is used up
            if (region_left_ff[cur_idx] == COUNT_BITS'(1)) begin
               cur_ff       <= cur_ff + REG_CNT_W'(1);
               remaining_ff <= remaining_ff - REG_CNT_W'(1);
            end
         end
         if (state_ff == ST_POP) begin
            count_ff <= pop_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_W'(ADD_LIMIT);
      end else if (csr_we) begin
         target_ff <= csr_wdata;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, count_ff, res_frame_ff};
         rsp_user_ff <= {res_status_ff, res_valid_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== bench/frame_alloc_checker.sv =====
// ----------------------------------------------------------------------------
// Frame allocator checker
// Watches the request, response and CSR ports. It keeps its own copy of the
// region table, the reserved list and the frame pool, works out the response
// for each accepted request, and compares each accepted response with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module frame_alloc_checker
   import pffla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   output int          fail_count,
   output int          owed_count
);

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic                  frame_valid;
      logic [POOL_CNT_W-1:0] pool_count;
      status_type            status;
   } alloc_rsp_type;

   alloc_rsp_type owed_rsp[$];

   logic [FRAME_BITS-1:0] region_base [MAX_REGIONS];
   logic [COUNT_BITS-1:0] region_left [MAX_REGIONS];
   int                    regions_loaded;
   int                    regions_remaining;
   int                    current_region;
   logic [FRAME_BITS-1:0] reserved_frame [MAX_RESERVED];
   int                    reserved_front;
   int                    reserved_end;
   logic [FRAME_BITS-1:0] pool_frame [POOL_DEPTH];
   int                    pool_fill;
   logic [TARGET_W-1:0]   refill_target;

   assign owed_count = owed_rsp.size();

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      fail_count++;
   endtask

   // Carve frames from the current region until the pool reaches the target.
   function automatic bit carve_pool();
      int                    goal;
      logic [FRAME_BITS-1:0] f;
      if (regions_remaining == 0 || current_region >= MAX_REGIONS) return 1'b0;
      goal = (refill_target == 0) ? 1 :
             (refill_target > ADD_LIMIT) ? ADD_LIMIT : int'(refill_target);
      while (pool_fill < goal && regions_remaining > 0 && current_region < MAX_REGIONS) begin
         f = region_base[current_region];
         if (reserved_front < reserved_end && reserved_frame[reserved_front] == f)
            reserved_front++;
         else if (pool_fill < POOL_DEPTH) begin
            pool_frame[pool_fill] = f;
            pool_fill++;
         end
         region_base[current_region] = f + 1'b1;
         region_left[current_region] = region_left[current_region] - 1'b1;
         if (region_left[current_region] == 0) begin
            current_region++;
            regions_remaining--;
         end
      end
      return 1'b1;
   endfunction

   function automatic alloc_rsp_type predict_alloc(logic [2:0] kind,
                                                   logic [FRAME_BITS-1:0] frame,
                                                   logic [COUNT_BITS-1:0] count);
      alloc_rsp_type r;
      r = '{frame: NULL_FRAME, frame_valid: 1'b0, pool_count: '0, status: STATUS_OK};
      case (kind)
         KIND_ADD_REGION: begin
            if (count != 0) begin
               if (regions_loaded < MAX_REGIONS) begin
                  region_base[regions_loaded] = frame;
                  region_left[regions_loaded] = count;
                  regions_loaded++;
                  regions_remaining++;
               end else begin
                  r.status = STATUS_FULL;
               end
            end
         end
         KIND_ADD_RESERVED: begin
            if (reserved_end < MAX_RESERVED) begin
               reserved_frame[reserved_end] = frame;
               reserved_end++;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         KIND_REFILL: begin
            if (!carve_pool()) r.status = STATUS_EMPTY;
         end
         KIND_ALLOC: begin
            if (pool_fill == 0) void'(carve_pool());
            if (pool_fill > 0) begin
               pool_fill--;
               r.frame       = pool_frame[pool_fill];
               r.frame_valid = 1'b1;
            end else begin
               r.status = STATUS_EMPTY;
            end
         end
         KIND_FREE: begin
            if (pool_fill >= POOL_DEPTH) r.status = STATUS_FULL;
            else begin
               pool_frame[pool_fill] = frame;
               pool_fill++;
            end
         end
         default: ;
      endcase
      r.pool_count = pool_fill[POOL_CNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         regions_loaded    = 0;
         regions_remaining = 0;
         current_region    = 0;
         reserved_front    = 0;
         reserved_end      = 1;
         reserved_frame[0] = NULL_FRAME;
         pool_fill         = 0;
         refill_target     = TARGET_W'(ADD_LIMIT);
         fail_count        = 0;
         owed_rsp.delete();
      end else begin
         if (csr_we) refill_target = csr_wdata;
         if (req_tvalid && req_tready)
            owed_rsp.push_back(predict_alloc(req_tuser, req_tdata[35:0],
                                             req_tdata[71:36]));
         if (rsp_tvalid && rsp_tready) begin
            if (owed_rsp.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_tdata), '0);
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_tdata[35:0] != want.frame)
                  report_mismatch("out_frame", rsp_tdata[35:0], want.frame);
               if (rsp_tuser[0] != want.frame_valid)
                  report_mismatch("frame_valid", rsp_tuser[0], want.frame_valid);
               if (rsp_tdata[46:36] != want.pool_count)
                  report_mismatch("pool_count", rsp_tdata[46:36], want.pool_count);
               if (rsp_tuser[2:1] != want.status)
                  report_mismatch("status", rsp_tuser[2:1], want.status);
            end
         end
      end
   end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Frame allocator testbench
// Drives region, reserved, refill, alloc, free and unused-kind requests with random gaps
// and response back-pressure, changes the refill target between phases, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb
   import pffla_pkg::*;
();

   localparam logic [FRAME_BITS-1:0] FRAME_TOP = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;
   int          fail_count;
   int          owed_count;
   bit          calm = 1'b0;
   bit          hold_req = 1'b0;

   logic [FRAME_BITS-1:0] next_base;
   int                    k;
   int                    roll;

   // Running count of region adds, started at 4; random adds stop at 14, leaving slots for the endless region.
   int regions_sent = 4;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   page_frame_free_list_allocator i_dut (.*);

   frame_alloc_checker i_checker (.*);

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            held = 1'b1;
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
      end
   end

   initial begin
      #100_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int region_slot_free();
      return (regions_sent < 14) ? 1 : 0;
   endfunction

   always @(posedge clock)
      if (req_tvalid && req_tready && req_tuser == KIND_ADD_REGION &&
          req_tdata[71:36] != 0)
         regions_sent <= regions_sent + 1;

   task automatic send_item(logic [2:0] kind, logic [FRAME_BITS-1:0] frame,
                            logic [COUNT_BITS-1:0] count);
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {count, frame};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold until every owed response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (owed_count == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_target(logic [6:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [35:0] rand36();
      return {4'($urandom_range(0, 15)), $urandom()};
   endfunction

   // One region at the running base with a few reserved frames inside it.
   task automatic add_region_block();
      logic [COUNT_BITS-1:0] span;
      logic [FRAME_BITS-1:0] res;
      span = COUNT_BITS'($urandom_range(1, 60));
      res  = next_base;
      repeat ($urandom_range(0, 3)) begin
         res = res + FRAME_BITS'($urandom_range(0, 9));
         if (res < next_base + span) send_item(KIND_ADD_RESERVED, res, rand36());
         res = res + 1'b1;
      end
      send_item(KIND_ADD_REGION, next_base, span);
      next_base = next_base + span + FRAME_BITS'($urandom_range(0, 20));
   endtask

   task automatic random_item();
      roll = $urandom_range(0, 99);
      if (roll < 45)      send_item(KIND_ALLOC, rand36(), rand36());
      else if (roll < 75) send_item(KIND_FREE, rand36(), rand36());
      else if (roll < 90) send_item(KIND_REFILL, rand36(), rand36());
      else                send_item(3'($urandom_range(5, 7)), rand36(), rand36());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_target(7'd2);

      // directed: skips, empty region, wrap, draining to empty, spare kinds
      send_item(KIND_ADD_REGION, '0, 36'd3);
      send_item(KIND_ADD_REGION, 36'd100, '0);
      send_item(KIND_ADD_RESERVED, 36'd5, '0);
      send_item(KIND_ADD_REGION, 36'd4, 36'd4);
      send_item(KIND_ADD_REGION, FRAME_TOP - 1'b1, 36'd3);
      send_item(KIND_REFILL, '0, '0);
      send_item(KIND_REFILL, '0, '0);
      send_item(KIND_ALLOC, '0, '0);
      send_item(KIND_FREE, FRAME_TOP, COUNT_TOP);
      repeat (9) send_item(KIND_ALLOC, '0, '0);
      send_item(KIND_REFILL, FRAME_TOP, COUNT_TOP);
      send_item(KIND_ALLOC, '0, '0);
      for (k = 5; k <= 7; k++) send_item(3'(k), rand36(), rand36());

      set_target(7'd64);
      next_base = 36'h1000;
      for (k = 0; k < 100; k++) begin
         if ($urandom_range(0, 99) < 8 && region_slot_free() > 0) add_region_block();
         else random_item();
      end

      set_target(7'd0);
      calm = 1'b1;
      add_region_block();
      repeat (40) random_item();
      calm = 1'b0;

      // a region that never runs dry
      set_target(7'd127);
      send_item(KIND_ADD_REGION, next_base, COUNT_TOP);
      send_item(KIND_ADD_REGION, rand36(), 36'd5);
      hold_req = 1'b1;
      repeat (40) send_item(KIND_ALLOC, '0, '0);
      set_target(7'($urandom_range(1, 63)));
      repeat (1040) send_item(KIND_FREE, rand36(), rand36());
      repeat (10) random_item();

      // fill the reserved table, then block skipping with an entry never met
      set_target(7'd64);
      repeat (260) begin
         next_base = next_base + 1'b1;
         send_item(KIND_ADD_RESERVED, next_base, rand36());
      end
      repeat (30) random_item();

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
